FILE: design/spectrum_thd_meter_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the spectrum THD meter
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef SPECTRUM_THD_METER_CORE_ASSERT_SVH
`define SPECTRUM_THD_METER_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define STM_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("stm: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define STM_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("stm: next-cycle check failed");

`endif

FILE: design/stm_pkg.sv
// ----------------------------------------------------------------------------
// stm_pkg
// Types and constants shared by the spectrum THD meter modules.
// ----------------------------------------------------------------------------
package stm_pkg;

	localparam int COMP_W  = 24;
	localparam int PWR_W   = 48;
	localparam int TOT_W   = 58;
	localparam int BIN_W   = 10;
	localparam int RATIO_W = 32;
	localparam int DATA_W  = 32;
	localparam int ADDR_W  = 3;

	// Register index is paddr[2]; the low two bits are the byte offset.
	localparam logic REG_HIGHEST_BIN = 1'b0;
	localparam logic [BIN_W-1:0] HIGHEST_BIN_RESET = 10'd511;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = 1;
	localparam int QCNT_W      = 2;

	typedef struct packed {
		logic [TOT_W-1:0] total;
		logic [PWR_W-1:0] peak;
		logic [BIN_W-1:0] bin;
	} stm_job_t;

	typedef struct packed {
		logic     push;
		stm_job_t job;
	} stm_qwr_t;

	typedef struct packed {
		logic              nonempty;
		logic [QCNT_W-1:0] count;
		stm_job_t          job;
	} stm_qrd_t;

endpackage

FILE: design/stm_front.sv
// ----------------------------------------------------------------------------
// stm_front
// Takes one bin per cycle while the queue has room, forms its power and keeps
// the frame's running total and peak; at frame end it queues the summary.
// ----------------------------------------------------------------------------
module stm_front #(
	parameter int FRAME_BINS = 1024
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [stm_pkg::COMP_W-1:0] bin_real,
	input  logic signed [stm_pkg::COMP_W-1:0] bin_imag,
	input  logic                              frame_end,
	input  logic [stm_pkg::BIN_W-1:0]         highest_bin,
	input  stm_pkg::stm_qrd_t                 qrd,
	output stm_pkg::stm_qwr_t                 qwr
);

	localparam int CNT_W = $clog2(FRAME_BINS);
	localparam int IDX_W = (CNT_W > stm_pkg::BIN_W) ? CNT_W : stm_pkg::BIN_W;
	localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(FRAME_BINS - 1);

	logic [CNT_W-1:0]          bin_counter_q;
	logic                      v_s1;
	logic                      last_s1;
	logic                      incl_s1;
	logic [stm_pkg::BIN_W-1:0] idx_s1;
	logic [stm_pkg::PWR_W-1:0] p_s1;

	logic [stm_pkg::TOT_W-1:0] power_total_q;
	logic [stm_pkg::PWR_W-1:0] peak_power_q;
	logic [stm_pkg::BIN_W-1:0] peak_bin_q;

	logic                      accept;
	logic [IDX_W-1:0]          idx_ext;
	logic [IDX_W-1:0]          top_ext;
	logic                      incl;
	logic signed [2*stm_pkg::COMP_W-1:0] re_sq;
	logic signed [2*stm_pkg::COMP_W-1:0] im_sq;
	logic [stm_pkg::QCNT_W:0]  need;
	logic [stm_pkg::TOT_W-1:0] total_next;
	logic                      new_peak;
	logic [stm_pkg::PWR_W-1:0] peak_next;
	logic [stm_pkg::BIN_W-1:0] bin_next;

	// A frame end sitting in stage 1 has a queue slot reserved for it.
	assign need     = (stm_pkg::QCNT_W+1)'(qrd.count) + (stm_pkg::QCNT_W+1)'(v_s1 && last_s1);
	assign in_ready = need < (stm_pkg::QCNT_W+1)'(stm_pkg::QUEUE_DEPTH);
	assign accept   = in_valid && in_ready;

	assign idx_ext = IDX_W'(bin_counter_q);
	assign top_ext = (highest_bin == '0) ? IDX_W'(1) : IDX_W'(highest_bin);
	assign incl    = (idx_ext != '0) && (idx_ext <= top_ext);
	assign re_sq   = bin_real * bin_real;
	assign im_sq   = bin_imag * bin_imag;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_counter_q <= '0;
			v_s1          <= 1'b0;
		end else begin
			v_s1 <= accept;
			if (accept) begin
				if (frame_end || bin_counter_q == LAST_IDX) begin
					bin_counter_q <= '0;
				end else begin
					bin_counter_q <= bin_counter_q + CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			last_s1 <= frame_end;
			incl_s1 <= incl;
			idx_s1  <= idx_ext[stm_pkg::BIN_W-1:0];
			p_s1    <= stm_pkg::PWR_W'(re_sq) + stm_pkg::PWR_W'(im_sq);
		end
	end

	assign total_next = incl_s1 ? power_total_q + stm_pkg::TOT_W'(p_s1) : power_total_q;
	assign new_peak   = incl_s1 && (p_s1 > peak_power_q);
	assign peak_next  = new_peak ? p_s1 : peak_power_q;
	assign bin_next   = new_peak ? idx_s1 : peak_bin_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			power_total_q <= '0;
			peak_power_q  <= '0;
			peak_bin_q    <= stm_pkg::BIN_W'(1);
		end else if (v_s1) begin
			if (last_s1) begin
				power_total_q <= '0;
				peak_power_q  <= '0;
				peak_bin_q    <= stm_pkg::BIN_W'(1);
			end else begin
				power_total_q <= total_next;
				peak_power_q  <= peak_next;
				peak_bin_q    <= bin_next;
			end
		end
	end

	assign qwr.push      = v_s1 && last_s1;
	assign qwr.job.total = total_next;
	assign qwr.job.peak  = peak_next;
	assign qwr.job.bin   = bin_next;

endmodule

FILE: design/stm_fifo.sv
// ----------------------------------------------------------------------------
// stm_fifo
// Short show-ahead queue of frame summaries between front and back.
// ----------------------------------------------------------------------------
`include "spectrum_thd_meter_core_assert.svh"

module stm_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  stm_pkg::stm_qwr_t qwr,
	input  logic              pop,
	output stm_pkg::stm_qrd_t qrd
);

	localparam logic [stm_pkg::QPTR_W-1:0] LAST_PTR = stm_pkg::QPTR_W'(stm_pkg::QUEUE_DEPTH - 1);

	stm_pkg::stm_job_t            mem_q [stm_pkg::QUEUE_DEPTH];
	logic [stm_pkg::QPTR_W-1:0]   wr_ptr_q;
	logic [stm_pkg::QPTR_W-1:0]   rd_ptr_q;
	logic [stm_pkg::QCNT_W-1:0]   count_q;

	always_ff @(posedge clk) begin
		if (qwr.push) begin
			mem_q[wr_ptr_q] <= qwr.job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (qwr.push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + stm_pkg::QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + stm_pkg::QPTR_W'(1);
			end
			if (qwr.push && !pop) begin
				count_q <= count_q + stm_pkg::QCNT_W'(1);
			end else if (pop && !qwr.push) begin
				count_q <= count_q - stm_pkg::QCNT_W'(1);
			end
		end
	end

	assign qrd.nonempty = count_q != '0;
	assign qrd.count    = count_q;
	assign qrd.job      = mem_q[rd_ptr_q];

	`STM_ASSERT_IMP(a_no_push_full, qwr.push, count_q < stm_pkg::QCNT_W'(stm_pkg::QUEUE_DEPTH))
	`STM_ASSERT_IMP(a_no_pop_empty, pop, count_q != '0)
	`STM_ASSERT_NXT(a_push_counts, qwr.push && !pop, count_q == $past(count_q) + stm_pkg::QCNT_W'(1))

endmodule

FILE: design/stm_back.sv
// ----------------------------------------------------------------------------
// stm_back
// Turns one frame summary into the THD ratio: a 64-step restoring divide and a
// 32-step square root and a result register; zero peak or overflow skips both.
// ----------------------------------------------------------------------------
`include "spectrum_thd_meter_core_assert.svh"

module stm_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  stm_pkg::stm_qrd_t           qrd,
	output logic                        pop,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [stm_pkg::RATIO_W-1:0] distortion_ratio,
	output logic [stm_pkg::BIN_W-1:0]   fundamental_bin,
	output logic                        no_fundamental
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_PREP = 3'd1;
	localparam logic [2:0] ST_DIV  = 3'd2;
	localparam logic [2:0] ST_SQRT = 3'd3;
	localparam logic [2:0] ST_FIN  = 3'd4;

	localparam int QN_W = 64;
	localparam int SR_W = 33;

	logic [2:0]                  state_q;
	logic [5:0]                  cnt_q;
	logic [stm_pkg::PWR_W-1:0]   m_q;
	logic [stm_pkg::TOT_W-1:0]   h_q;
	logic [stm_pkg::PWR_W-1:0]   rem_q;
	logic [QN_W-1:0]             qn_q;
	logic [SR_W-1:0]             srem_q;
	logic [stm_pkg::RATIO_W-1:0] root_q;
	logic [stm_pkg::RATIO_W-1:0] res_ratio_q;
	logic [stm_pkg::BIN_W-1:0]   res_bin_q;
	logic                        res_nf_q;
	logic                        out_valid_q;
	logic [stm_pkg::RATIO_W-1:0] ratio_q;
	logic [stm_pkg::BIN_W-1:0]   fbin_q;
	logic                        nf_q;

	logic [stm_pkg::PWR_W:0]     div_r;
	logic                        div_ge;
	logic [SR_W+1:0]             sq_r;
	logic [SR_W+1:0]             sq_t;
	logic                        sq_ge;
	logic                        out_free;

	assign pop = (state_q == ST_IDLE) && qrd.nonempty;

	assign div_r  = {rem_q, qn_q[QN_W-1]};
	assign div_ge = div_r >= {1'b0, m_q};
	assign sq_r   = {srem_q, qn_q[QN_W-1:QN_W-2]};
	assign sq_t   = {1'b0, root_q, 2'b01};
	assign sq_ge  = sq_r >= sq_t;

	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (qrd.nonempty) begin
						state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					if (m_q == '0 || {6'b0, h_q} >= {m_q, 16'b0}) begin
						state_q <= ST_FIN;
					end else begin
						state_q <= ST_DIV;
						cnt_q   <= 6'd63;
					end
				end
				ST_DIV: begin
					if (cnt_q == '0) begin
						state_q <= ST_SQRT;
						cnt_q   <= 6'd31;
					end else begin
						cnt_q <= cnt_q - 6'd1;
					end
				end
				ST_SQRT: begin
					if (cnt_q == '0) begin
						state_q <= ST_FIN;
					end else begin
						cnt_q <= cnt_q - 6'd1;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				m_q       <= qrd.job.peak;
				res_bin_q <= qrd.job.bin;
				h_q       <= (qrd.job.total >= stm_pkg::TOT_W'(qrd.job.peak))
					? qrd.job.total - stm_pkg::TOT_W'(qrd.job.peak) : '0;
			end
			ST_PREP: begin
				rem_q    <= stm_pkg::PWR_W'(h_q[stm_pkg::TOT_W-1:16]);
				qn_q     <= {h_q[15:0], 48'b0};
				srem_q   <= '0;
				root_q   <= '0;
				res_nf_q <= m_q == '0;
				if (m_q == '0) begin
					res_ratio_q <= '0;
					res_bin_q   <= stm_pkg::BIN_W'(1);
				end else begin
					res_ratio_q <= '1;
				end
			end
			ST_DIV: begin
				// The numerator bits enter at the top while quotient bits fill the bottom.
				rem_q <= div_ge ? stm_pkg::PWR_W'(div_r - {1'b0, m_q})
					: div_r[stm_pkg::PWR_W-1:0];
				qn_q  <= {qn_q[QN_W-2:0], div_ge};
			end
			ST_SQRT: begin
				srem_q <= sq_ge ? SR_W'(sq_r - sq_t) : sq_r[SR_W-1:0];
				root_q <= {root_q[stm_pkg::RATIO_W-2:0], sq_ge};
				qn_q   <= {qn_q[QN_W-3:0], 2'b00};
				if (cnt_q == '0) begin
					res_ratio_q <= {root_q[stm_pkg::RATIO_W-2:0], sq_ge};
				end
			end
			ST_FIN: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_FIN && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FIN && out_free) begin
			ratio_q <= res_ratio_q;
			fbin_q  <= res_bin_q;
			nf_q    <= res_nf_q;
		end
	end

	assign out_valid        = out_valid_q;
	assign distortion_ratio = ratio_q;
	assign fundamental_bin  = fbin_q;
	assign no_fundamental   = nf_q;

	`STM_ASSERT_IMP(a_div_nonzero, state_q == ST_DIV || state_q == ST_SQRT, m_q != '0)
	`STM_ASSERT_NXT(a_div_to_sqrt, state_q == ST_DIV && cnt_q == '0, state_q == ST_SQRT)
	`STM_ASSERT_IMP(a_nf_result, out_valid_q && nf_q, ratio_q == '0 && fbin_q == stm_pkg::BIN_W'(1))

endmodule

FILE: design/spectrum_thd_meter_core.sv
// ----------------------------------------------------------------------------
// spectrum_thd_meter_core
// THD of a complex spectrum: power sum and peak search per bin, then
// sqrt((total - peak) / peak) in unsigned Q8.24 once per frame.
// ----------------------------------------------------------------------------
// Throughput: one bin per cycle; the front holds it while the summary queue is full.
// After the frame-end transfer the back unit forms the result by a 64-step divide
// and a 32-step square root, both skipped on special cases.
// A frame summary is queued in the cycle after its last bin; two summaries can wait.
// Reset clears the bin counter, the frame sums, the queue and the result valid flag,
// and sets highest_bin to 511.
module spectrum_thd_meter_core #(
	parameter int FRAME_BINS = 1024
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [stm_pkg::ADDR_W-1:0]         paddr,
	input  logic [stm_pkg::DATA_W-1:0]         pwdata,
	output logic [stm_pkg::DATA_W-1:0]         prdata,
	output logic                               pready,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic signed [stm_pkg::COMP_W-1:0]  bin_real,
	input  logic signed [stm_pkg::COMP_W-1:0]  bin_imag,
	input  logic                               frame_end,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [stm_pkg::RATIO_W-1:0]        distortion_ratio,
	output logic [stm_pkg::BIN_W-1:0]          fundamental_bin,
	output logic                               no_fundamental
);

	logic [stm_pkg::BIN_W-1:0] highest_bin_q;
	stm_pkg::stm_qwr_t         qwr;
	stm_pkg::stm_qrd_t         qrd;
	logic                      pop;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			highest_bin_q <= stm_pkg::HIGHEST_BIN_RESET;
		end else if (psel && penable && pwrite && paddr[2] == stm_pkg::REG_HIGHEST_BIN) begin
			highest_bin_q <= pwdata[stm_pkg::BIN_W-1:0];
		end
	end

	assign prdata = (paddr[2] == stm_pkg::REG_HIGHEST_BIN)
		? stm_pkg::DATA_W'(highest_bin_q) : '0;

	stm_front #(
		.FRAME_BINS(FRAME_BINS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.bin_real   (bin_real),
		.bin_imag   (bin_imag),
		.frame_end  (frame_end),
		.highest_bin(highest_bin_q),
		.qrd        (qrd),
		.qwr        (qwr)
	);

	stm_fifo u_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.qwr   (qwr),
		.pop   (pop),
		.qrd   (qrd)
	);

	stm_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.qrd             (qrd),
		.pop             (pop),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.distortion_ratio(distortion_ratio),
		.fundamental_bin (fundamental_bin),
		.no_fundamental  (no_fundamental)
	);

endmodule
